/* design/gdn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdn_pkg
// Shared widths, constants, month tables and pipeline control type for the
// Gregorian date-time day-number block.
// ----------------------------------------------------------------------------
package gdn_pkg;

	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MIN_W    = 6;
	localparam int SEC_W    = 6;
	localparam int JDN_W    = 23;
	localparam int SOD_W    = 17;
	localparam int WD_W     = 3;
	localparam int CENT_W   = 8;
	localparam int KTERM_W  = 13;
	localparam int MTERM_W  = 9;
	localparam int REM_W    = 12;

	localparam int NUM_STAGES = 10;

	// stage indexes into the load-enable vector
	localparam int ST_CENT   = 0;
	localparam int ST_LEAP   = 1;
	localparam int ST_YMUL   = 2;
	localparam int ST_JDN    = 3;
	localparam int ST_DIFF   = 4;
	localparam int ST_ABS    = 5;
	localparam int ST_HMUL   = 6;
	localparam int ST_HSPLIT = 7;
	localparam int ST_MMUL   = 8;
	localparam int ST_OUT    = 9;

	localparam int FIRST_YEAR    = 1582;
	localparam int YEAR_OFFSET   = 4716;
	localparam int YEAR_DAYS_X4  = 1461;
	localparam int JDN_BIAS      = 1522;	// 1524 less the constant 2 of the B term
	localparam int SECS_PER_DAY  = 86400;
	localparam int SECS_PER_HOUR = 3600;
	localparam int SECS_PER_MIN  = 60;

	// reciprocal multipliers: floor(x / d) = (x * R) >> S over the ranges used
	localparam int CENT_RECIP = 10486;
	localparam int CENT_SHIFT = 20;
	localparam int HOUR_RECIP = 37283;
	localparam int HOUR_SHIFT = 27;
	localparam int MIN_RECIP  = 4370;
	localparam int MIN_SHIFT  = 18;
	localparam int WEEK_RECIP = 9586981;
	localparam int WEEK_SHIFT = 26;

	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
	} gdn_ctl_t;

	// days in month, February as a common year
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] r;
		case (m)
			4'd2:                      r = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
			default:                   r = 5'd31;
		endcase
		return r;
	endfunction

	// floor(30.6001*(m'+1)), with January and February as months 13 and 14
	function automatic logic [MTERM_W-1:0] month_term(input logic [MONTH_W-1:0] m);
		logic [MTERM_W-1:0] r;
		case (m)
			4'd1:    r = 9'd428;
			4'd2:    r = 9'd459;
			4'd3:    r = 9'd122;
			4'd4:    r = 9'd153;
			4'd5:    r = 9'd183;
			4'd6:    r = 9'd214;
			4'd7:    r = 9'd244;
			4'd8:    r = 9'd275;
			4'd9:    r = 9'd306;
			4'd10:   r = 9'd336;
			4'd11:   r = 9'd367;
			4'd12:   r = 9'd397;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

/* design/gdn_pipe_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdn_pipe_ctrl
// Valid bits and per-stage load enables; a stage loads when it is empty or
// its successor is loading, so bubbles close up during an output stall.
// ----------------------------------------------------------------------------
module gdn_pipe_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output gdn_pkg::gdn_ctl_t ctl
);

	logic [gdn_pkg::NUM_STAGES-1:0] vld_q;
	logic [gdn_pkg::NUM_STAGES-1:0] rdy;

	always_comb begin
		rdy[gdn_pkg::NUM_STAGES-1] = !vld_q[gdn_pkg::NUM_STAGES-1] || out_ready;
		for (int k = gdn_pkg::NUM_STAGES-2; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < gdn_pkg::NUM_STAGES; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign ctl.en    = rdy;
	assign in_ready  = rdy[0];
	assign out_valid = vld_q[gdn_pkg::NUM_STAGES-1];

endmodule

/* design/gdn_date_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdn_date_unit
// Four-stage check and Julian day number of one date-time, plus its
// seconds since midnight.
// ----------------------------------------------------------------------------
module gdn_date_unit (
	input  logic                             clk,
	input  gdn_pkg::gdn_ctl_t                ctl,
	input  logic [gdn_pkg::YEAR_W-1:0]       year,
	input  logic [gdn_pkg::MONTH_W-1:0]      month,
	input  logic [gdn_pkg::DAY_W-1:0]        day,
	input  logic [gdn_pkg::HOUR_W-1:0]       hour,
	input  logic [gdn_pkg::MIN_W-1:0]        minute,
	input  logic [gdn_pkg::SEC_W-1:0]        second,
	output logic [gdn_pkg::JDN_W-1:0]        day_number,
	output logic [gdn_pkg::SOD_W-1:0]        seconds_of_day,
	output logic                             stamp_ok
);

	localparam int CPROD_W = gdn_pkg::YEAR_W + gdn_pkg::YEAR_W;
	localparam int YA_W    = gdn_pkg::YEAR_W + 1;
	localparam int YPROD_W = YA_W + 11;

	// stage 1: century by reciprocal, seconds of day, range checks
	logic [CPROD_W-1:0]          cent_prod;
	logic [gdn_pkg::SOD_W-1:0]   sod;
	logic                        base_ok;

	logic [gdn_pkg::YEAR_W-1:0]  year_s1;
	logic [gdn_pkg::MONTH_W-1:0] month_s1;
	logic [gdn_pkg::DAY_W-1:0]   day_s1;
	logic [gdn_pkg::CENT_W-1:0]  cent_s1;
	logic [gdn_pkg::SOD_W-1:0]   sod_s1;
	logic                        base_ok_s1;
	logic                        day_fits_s1;
	logic                        feb29_s1;

	assign cent_prod = CPROD_W'(year) * CPROD_W'(gdn_pkg::CENT_RECIP);
	assign sod = gdn_pkg::SOD_W'(hour) * gdn_pkg::SOD_W'(gdn_pkg::SECS_PER_HOUR)
		+ gdn_pkg::SOD_W'(minute) * gdn_pkg::SOD_W'(gdn_pkg::SECS_PER_MIN)
		+ gdn_pkg::SOD_W'(second);
	assign base_ok = (year >= gdn_pkg::YEAR_W'(gdn_pkg::FIRST_YEAR))
		&& (month >= 4'd1) && (month <= 4'd12) && (day != '0)
		&& (hour < 5'd24) && (minute < 6'd60) && (second < 6'd60);

	always_ff @(posedge clk) begin
		if (ctl.en[gdn_pkg::ST_CENT]) begin
			year_s1     <= year;
			month_s1    <= month;
			day_s1      <= day;
			cent_s1     <= cent_prod[gdn_pkg::CENT_SHIFT +: gdn_pkg::CENT_W];
			sod_s1      <= sod;
			base_ok_s1  <= base_ok;
			day_fits_s1 <= day <= gdn_pkg::month_len(month);
			feb29_s1    <= (month == 4'd2) && (day == 5'd29);
		end
	end

	// stage 2: leap year, January/February shift, small day-number terms
	logic [gdn_pkg::YEAR_W-1:0]  rem_full;
	logic                        rem_zero;
	logic                        leap;
	logic                        early;
	logic [gdn_pkg::YEAR_W-1:0]  yadj;
	logic [gdn_pkg::CENT_W-1:0]  cadj;
	logic [gdn_pkg::KTERM_W-1:0] kterm;

	logic [YA_W-1:0]             ya_s2;
	logic [gdn_pkg::KTERM_W-1:0] kterm_s2;
	logic [gdn_pkg::SOD_W-1:0]   sod_s2;
	logic                        ok_s2;

	assign rem_full = year_s1 - gdn_pkg::YEAR_W'(cent_s1) * gdn_pkg::YEAR_W'(100);
	assign rem_zero = (rem_full == '0);
	assign leap     = ((year_s1[1:0] == 2'd0) && !rem_zero)
		|| (rem_zero && (cent_s1[1:0] == 2'd0));
	assign early    = (month_s1 <= 4'd2);
	assign yadj     = year_s1 - gdn_pkg::YEAR_W'(early);
	// year-1 drops a century only when year is a multiple of 100
	assign cadj     = (early && rem_zero) ? cent_s1 - 8'd1 : cent_s1;
	assign kterm    = gdn_pkg::KTERM_W'(gdn_pkg::month_term(month_s1))
		+ gdn_pkg::KTERM_W'(day_s1)
		+ gdn_pkg::KTERM_W'(cadj >> 2)
		- gdn_pkg::KTERM_W'(cadj)
		- gdn_pkg::KTERM_W'(gdn_pkg::JDN_BIAS);

	always_ff @(posedge clk) begin
		if (ctl.en[gdn_pkg::ST_LEAP]) begin
			ya_s2    <= YA_W'(yadj) + YA_W'(gdn_pkg::YEAR_OFFSET);
			kterm_s2 <= kterm;
			sod_s2   <= sod_s1;
			ok_s2    <= base_ok_s1 && (day_fits_s1 || (feb29_s1 && leap));
		end
	end

	// stage 3: year term product
	logic [YPROD_W-1:0]          yprod_s3;
	logic [gdn_pkg::KTERM_W-1:0] kterm_s3;
	logic [gdn_pkg::SOD_W-1:0]   sod_s3;
	logic                        ok_s3;

	always_ff @(posedge clk) begin
		if (ctl.en[gdn_pkg::ST_YMUL]) begin
			yprod_s3 <= YPROD_W'(ya_s2) * YPROD_W'(gdn_pkg::YEAR_DAYS_X4);
			kterm_s3 <= kterm_s2;
			sod_s3   <= sod_s2;
			ok_s3    <= ok_s2;
		end
	end

	// stage 4: day number
	logic [gdn_pkg::JDN_W-1:0] jdn_s4;
	logic [gdn_pkg::SOD_W-1:0] sod_s4;
	logic                      ok_s4;

	always_ff @(posedge clk) begin
		if (ctl.en[gdn_pkg::ST_JDN]) begin
			jdn_s4 <= yprod_s3[gdn_pkg::JDN_W+1:2]
				+ {{(gdn_pkg::JDN_W-gdn_pkg::KTERM_W){kterm_s3[gdn_pkg::KTERM_W-1]}},
					kterm_s3};
			sod_s4 <= sod_s3;
			ok_s4  <= ok_s3;
		end
	end

	assign day_number     = jdn_s4;
	assign seconds_of_day = sod_s4;
	assign stamp_ok       = ok_s4;

endmodule

/* design/gdn_gap_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdn_gap_unit
// Six-stage weekday and absolute difference split into days, hours,
// minutes and seconds; the last stage is the output register.
// ----------------------------------------------------------------------------
module gdn_gap_unit (
	input  logic                        clk,
	input  gdn_pkg::gdn_ctl_t           ctl,
	input  logic [gdn_pkg::JDN_W-1:0]   first_jdn,
	input  logic [gdn_pkg::SOD_W-1:0]   first_sod,
	input  logic                        first_ok,
	input  logic [gdn_pkg::JDN_W-1:0]   other_jdn,
	input  logic [gdn_pkg::SOD_W-1:0]   other_sod,
	input  logic                        other_ok,
	output logic                        both_valid,
	output logic [gdn_pkg::JDN_W-1:0]   first_day_number,
	output logic [gdn_pkg::SOD_W-1:0]   first_seconds_of_day,
	output logic [gdn_pkg::WD_W-1:0]    weekday,
	output logic [gdn_pkg::JDN_W-1:0]   gap_days,
	output logic [gdn_pkg::HOUR_W-1:0]  gap_hours,
	output logic [gdn_pkg::MIN_W-1:0]   gap_minutes,
	output logic [gdn_pkg::SEC_W-1:0]   gap_seconds
);

	localparam int DJ_W    = gdn_pkg::JDN_W + 1;
	localparam int DS_W    = gdn_pkg::SOD_W + 1;
	localparam int WPROD_W = gdn_pkg::JDN_W + 24;
	localparam int HPROD_W = gdn_pkg::SOD_W + 16;
	localparam int MPROD_W = gdn_pkg::REM_W + 13;

	// stage 5: signed differences, weekday quotient
	logic [WPROD_W-1:0]        wprod;
	logic [DJ_W-1:0]           dj_s5;
	logic [DS_W-1:0]           ds_s5;
	logic [2:0]                q_s5;
	logic [gdn_pkg::JDN_W-1:0] jdn_s5;
	logic [gdn_pkg::SOD_W-1:0] sod_s5;
	logic                      ok_s5;

	assign wprod = WPROD_W'(first_jdn) * WPROD_W'(gdn_pkg::WEEK_RECIP);

	always_ff @(posedge clk) begin
		if (ctl.en[gdn_pkg::ST_DIFF]) begin
			dj_s5  <= {1'b0, first_jdn} - {1'b0, other_jdn};
			ds_s5  <= {1'b0, first_sod} - {1'b0, other_sod};
			q_s5   <= wprod[gdn_pkg::WEEK_SHIFT +: 3];
			jdn_s5 <= first_jdn;
			sod_s5 <= first_sod;
			ok_s5  <= first_ok && other_ok;
		end
	end

	// stage 6: absolute value with a borrow of one day when the seconds go negative
	logic                       neg;
	logic                       ds_neg;
	logic                       ds_pos;
	logic [DJ_W-1:0]            pos_days;
	logic [DJ_W-1:0]            neg_days;
	logic [DS_W-1:0]            pos_secs;
	logic [DS_W-1:0]            neg_secs;

	logic [gdn_pkg::JDN_W-1:0]  days_s6;
	logic [gdn_pkg::SOD_W-1:0]  secs_s6;
	logic [gdn_pkg::WD_W-1:0]   wd_s6;
	logic [gdn_pkg::JDN_W-1:0]  jdn_s6;
	logic [gdn_pkg::SOD_W-1:0]  sod_s6;
	logic                       ok_s6;

	assign ds_neg   = ds_s5[DS_W-1];
	assign ds_pos   = !ds_neg && (ds_s5 != '0);
	assign neg      = dj_s5[DJ_W-1] || ((dj_s5 == '0) && ds_neg);
	assign pos_days = dj_s5 - DJ_W'(ds_neg);
	assign neg_days = -dj_s5 - DJ_W'(ds_pos);
	assign pos_secs = ds_neg ? ds_s5 + DS_W'(gdn_pkg::SECS_PER_DAY) : ds_s5;
	assign neg_secs = ds_pos ? DS_W'(gdn_pkg::SECS_PER_DAY) - ds_s5 : -ds_s5;

	always_ff @(posedge clk) begin
		if (ctl.en[gdn_pkg::ST_ABS]) begin
			days_s6 <= gdn_pkg::JDN_W'(neg ? neg_days : pos_days);
			secs_s6 <= gdn_pkg::SOD_W'(neg ? neg_secs : pos_secs);
			wd_s6   <= 3'(jdn_s5[2:0] + 3'd1 - 3'(q_s5 * 3'd7));
			jdn_s6  <= jdn_s5;
			sod_s6  <= sod_s5;
			ok_s6   <= ok_s5;
		end
	end

	// stage 7: hours by reciprocal
	logic [HPROD_W-1:0]         hprod_s7;
	logic [gdn_pkg::SOD_W-1:0]  secs_s7;
	logic [gdn_pkg::JDN_W-1:0]  days_s7;
	logic [gdn_pkg::WD_W-1:0]   wd_s7;
	logic [gdn_pkg::JDN_W-1:0]  jdn_s7;
	logic [gdn_pkg::SOD_W-1:0]  sod_s7;
	logic                       ok_s7;

	always_ff @(posedge clk) begin
		if (ctl.en[gdn_pkg::ST_HMUL]) begin
			hprod_s7 <= HPROD_W'(secs_s6) * HPROD_W'(gdn_pkg::HOUR_RECIP);
			secs_s7  <= secs_s6;
			days_s7  <= days_s6;
			wd_s7    <= wd_s6;
			jdn_s7   <= jdn_s6;
			sod_s7   <= sod_s6;
			ok_s7    <= ok_s6;
		end
	end

	// stage 8: remainder within the hour
	logic [gdn_pkg::HOUR_W-1:0] hrs;
	logic [gdn_pkg::HOUR_W-1:0] hrs_s8;
	logic [gdn_pkg::REM_W-1:0]  r2_s8;
	logic [gdn_pkg::JDN_W-1:0]  days_s8;
	logic [gdn_pkg::WD_W-1:0]   wd_s8;
	logic [gdn_pkg::JDN_W-1:0]  jdn_s8;
	logic [gdn_pkg::SOD_W-1:0]  sod_s8;
	logic                       ok_s8;

	assign hrs = hprod_s7[gdn_pkg::HOUR_SHIFT +: gdn_pkg::HOUR_W];

	always_ff @(posedge clk) begin
		if (ctl.en[gdn_pkg::ST_HSPLIT]) begin
			hrs_s8  <= hrs;
			r2_s8   <= gdn_pkg::REM_W'(secs_s7
				- gdn_pkg::SOD_W'(hrs) * gdn_pkg::SOD_W'(gdn_pkg::SECS_PER_HOUR));
			days_s8 <= days_s7;
			wd_s8   <= wd_s7;
			jdn_s8  <= jdn_s7;
			sod_s8  <= sod_s7;
			ok_s8   <= ok_s7;
		end
	end

	// stage 9: minutes by reciprocal
	logic [MPROD_W-1:0]         mprod_s9;
	logic [gdn_pkg::REM_W-1:0]  r2_s9;
	logic [gdn_pkg::HOUR_W-1:0] hrs_s9;
	logic [gdn_pkg::JDN_W-1:0]  days_s9;
	logic [gdn_pkg::WD_W-1:0]   wd_s9;
	logic [gdn_pkg::JDN_W-1:0]  jdn_s9;
	logic [gdn_pkg::SOD_W-1:0]  sod_s9;
	logic                       ok_s9;

	always_ff @(posedge clk) begin
		if (ctl.en[gdn_pkg::ST_MMUL]) begin
			mprod_s9 <= MPROD_W'(r2_s8) * MPROD_W'(gdn_pkg::MIN_RECIP);
			r2_s9    <= r2_s8;
			hrs_s9   <= hrs_s8;
			days_s9  <= days_s8;
			wd_s9    <= wd_s8;
			jdn_s9   <= jdn_s8;
			sod_s9   <= sod_s8;
			ok_s9    <= ok_s8;
		end
	end

	// stage 10: seconds, zeroing of an invalid pair, output register
	logic [gdn_pkg::MIN_W-1:0] mins;
	logic [gdn_pkg::SEC_W-1:0] secs;

	logic                       both_valid_s10;
	logic [gdn_pkg::JDN_W-1:0]  jdn_s10;
	logic [gdn_pkg::SOD_W-1:0]  sod_s10;
	logic [gdn_pkg::WD_W-1:0]   wd_s10;
	logic [gdn_pkg::JDN_W-1:0]  days_s10;
	logic [gdn_pkg::HOUR_W-1:0] hrs_s10;
	logic [gdn_pkg::MIN_W-1:0]  mins_s10;
	logic [gdn_pkg::SEC_W-1:0]  secs_s10;

	assign mins = mprod_s9[gdn_pkg::MIN_SHIFT +: gdn_pkg::MIN_W];
	assign secs = gdn_pkg::SEC_W'(r2_s9
		- gdn_pkg::REM_W'(mins) * gdn_pkg::REM_W'(gdn_pkg::SECS_PER_MIN));

	always_ff @(posedge clk) begin
		if (ctl.en[gdn_pkg::ST_OUT]) begin
			both_valid_s10 <= ok_s9;
			jdn_s10        <= ok_s9 ? jdn_s9  : '0;
			sod_s10        <= ok_s9 ? sod_s9  : '0;
			wd_s10         <= ok_s9 ? wd_s9   : '0;
			days_s10       <= ok_s9 ? days_s9 : '0;
			hrs_s10        <= ok_s9 ? hrs_s9  : '0;
			mins_s10       <= ok_s9 ? mins    : '0;
			secs_s10       <= ok_s9 ? secs    : '0;
		end
	end

	assign both_valid           = both_valid_s10;
	assign first_day_number     = jdn_s10;
	assign first_seconds_of_day = sod_s10;
	assign weekday              = wd_s10;
	assign gap_days             = days_s10;
	assign gap_hours            = hrs_s10;
	assign gap_minutes          = mins_s10;
	assign gap_seconds          = secs_s10;

endmodule

/* design/gregorian_datetime_day_number.sv */
`timescale 1ns / 1ps
// Throughput: one transaction per cycle while the output is not stalled; every stage
// is a single register step and the day number, weekday and time split use constant
// multipliers only. Reset (arst_n low, asynchronous) clears the stage valid bits;
// payload registers are not reset. A stalled output holds its result while earlier
// stages keep filling.
// ----------------------------------------------------------------------------
// gregorian_datetime_day_number
// Validates two Gregorian date-times, gives the Julian day number, seconds of
// day and weekday of the first, and the absolute gap between the two.
// ----------------------------------------------------------------------------
module gregorian_datetime_day_number (
	input  logic                            clk,
	input  logic                            arst_n,
	// input channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [gdn_pkg::YEAR_W-1:0]      first_year,
	input  logic [gdn_pkg::MONTH_W-1:0]     first_month,
	input  logic [gdn_pkg::DAY_W-1:0]       first_day,
	input  logic [gdn_pkg::HOUR_W-1:0]      first_hour,
	input  logic [gdn_pkg::MIN_W-1:0]       first_minute,
	input  logic [gdn_pkg::SEC_W-1:0]       first_second,
	input  logic [gdn_pkg::YEAR_W-1:0]      other_year,
	input  logic [gdn_pkg::MONTH_W-1:0]     other_month,
	input  logic [gdn_pkg::DAY_W-1:0]       other_day,
	input  logic [gdn_pkg::HOUR_W-1:0]      other_hour,
	input  logic [gdn_pkg::MIN_W-1:0]       other_minute,
	input  logic [gdn_pkg::SEC_W-1:0]       other_second,
	// output channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            both_valid,
	output logic [gdn_pkg::JDN_W-1:0]       first_day_number,
	output logic [gdn_pkg::SOD_W-1:0]       first_seconds_of_day,
	output logic [gdn_pkg::WD_W-1:0]        weekday,
	output logic [gdn_pkg::JDN_W-1:0]       gap_days,
	output logic [gdn_pkg::HOUR_W-1:0]      gap_hours,
	output logic [gdn_pkg::MIN_W-1:0]       gap_minutes,
	output logic [gdn_pkg::SEC_W-1:0]       gap_seconds
);

	// Stage plan
	//   1  century of the year (x/100 by reciprocal), seconds of day, range checks
	//   2  leap year, Jan/Feb folded into the previous year, small day-number terms
	//   3  1461*(y+4716) product
	//   4  Julian day number
	//   5  signed day and second differences, weekday quotient (x/7 by reciprocal)
	//   6  absolute gap with a one-day borrow when the seconds part goes negative
	//   7  hour quotient product
	//   8  hours and remainder within the hour
	//   9  minute quotient product
	//   10 minutes and seconds, invalid pairs forced to zero; output register
	// Stages 1-4 run twice in parallel, once per date-time.

	gdn_pkg::gdn_ctl_t ctl;

	logic [gdn_pkg::JDN_W-1:0] first_jdn;
	logic [gdn_pkg::SOD_W-1:0] first_sod;
	logic                      first_ok;
	logic [gdn_pkg::JDN_W-1:0] other_jdn;
	logic [gdn_pkg::SOD_W-1:0] other_sod;
	logic                      other_ok;

	// handshake and stage enables; ready ripples back so bubbles are squeezed out
	gdn_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	gdn_date_unit u_first (
		.clk            (clk),
		.ctl            (ctl),
		.year           (first_year),
		.month          (first_month),
		.day            (first_day),
		.hour           (first_hour),
		.minute         (first_minute),
		.second         (first_second),
		.day_number     (first_jdn),
		.seconds_of_day (first_sod),
		.stamp_ok       (first_ok)
	);

	gdn_date_unit u_other (
		.clk            (clk),
		.ctl            (ctl),
		.year           (other_year),
		.month          (other_month),
		.day            (other_day),
		.hour           (other_hour),
		.minute         (other_minute),
		.second         (other_second),
		.day_number     (other_jdn),
		.seconds_of_day (other_sod),
		.stamp_ok       (other_ok)
	);

	// difference, weekday and the final output register
	gdn_gap_unit u_gap (
		.clk                  (clk),
		.ctl                  (ctl),
		.first_jdn            (first_jdn),
		.first_sod            (first_sod),
		.first_ok             (first_ok),
		.other_jdn            (other_jdn),
		.other_sod            (other_sod),
		.other_ok             (other_ok),
		.both_valid           (both_valid),
		.first_day_number     (first_day_number),
		.first_seconds_of_day (first_seconds_of_day),
		.weekday              (weekday),
		.gap_days             (gap_days),
		.gap_hours            (gap_hours),
		.gap_minutes          (gap_minutes),
		.gap_seconds          (gap_seconds)
	);

endmodule

/* design/gdn_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdn_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module gdn_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        both_valid,
	input logic [gdn_pkg::JDN_W-1:0]   first_day_number,
	input logic [gdn_pkg::SOD_W-1:0]   first_seconds_of_day,
	input logic [gdn_pkg::WD_W-1:0]    weekday,
	input logic [gdn_pkg::JDN_W-1:0]   gap_days,
	input logic [gdn_pkg::HOUR_W-1:0]  gap_hours,
	input logic [gdn_pkg::MIN_W-1:0]   gap_minutes,
	input logic [gdn_pkg::SEC_W-1:0]   gap_seconds
);

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(first_day_number)
			&& $stable(gap_days) && $stable(both_valid))
		else $error("result changed while stalled");

	// an invalid pair gives an all-zero result
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !both_valid |-> first_day_number == '0 && first_seconds_of_day == '0
			&& weekday == '0 && gap_days == '0 && gap_hours == '0
			&& gap_minutes == '0 && gap_seconds == '0)
		else $error("invalid transaction has non-zero fields");

	// a valid pair gives a weekday and a gap split in range
	a_valid_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && both_valid |-> weekday != '0 && gap_hours < 5'd24
			&& gap_minutes < 6'd60 && gap_seconds < 6'd60
			&& first_seconds_of_day < gdn_pkg::SOD_W'(gdn_pkg::SECS_PER_DAY))
		else $error("valid transaction has a field out of range");

	// with room in the pipe, the input is never refused while the output drains
	a_ready_when_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled although the output is being taken");

endmodule

bind gregorian_datetime_day_number gdn_checker u_gdn_checker (.*);

/* tb/gregorian_datetime_day_number_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_datetime_day_number_tb
// Self-checking bench for the date-time day-number block. Date-time pairs are
// queued by the stimulus process, then offered by a falling-edge driver with
// random idle gaps. A rising-edge monitor predicts each accepted transaction
// and checks the returned results in order, while the receiver stalls at
// random.
// ----------------------------------------------------------------------------
module gregorian_datetime_day_number_tb;

	// one Gregorian date-time as the ports carry it
	typedef struct packed {
		logic [gdn_pkg::YEAR_W-1:0]  year;
		logic [gdn_pkg::MONTH_W-1:0] month;
		logic [gdn_pkg::DAY_W-1:0]   day;
		logic [gdn_pkg::HOUR_W-1:0]  hour;
		logic [gdn_pkg::MIN_W-1:0]   minute;
		logic [gdn_pkg::SEC_W-1:0]   second;
	} stamp_t;

	// one input transaction; hold_for_drain makes the sender wait for an empty pipe
	typedef struct packed {
		stamp_t first;
		stamp_t other;
		bit     hold_for_drain;
	} stamp_pair_t;

	typedef struct packed {
		logic                        both_valid;
		logic [gdn_pkg::JDN_W-1:0]   first_day_number;
		logic [gdn_pkg::SOD_W-1:0]   first_seconds_of_day;
		logic [gdn_pkg::WD_W-1:0]    weekday;
		logic [gdn_pkg::JDN_W-1:0]   gap_days;
		logic [gdn_pkg::HOUR_W-1:0]  gap_hours;
		logic [gdn_pkg::MIN_W-1:0]   gap_minutes;
		logic [gdn_pkg::SEC_W-1:0]   gap_seconds;
	} day_result_t;

	localparam int unsigned DAY_SECONDS  = 86400;
	localparam int          RANDOM_PAIRS = 1630;
	localparam int          LONG_STALL_AT     = 400;	// results seen before the long hold-off
	localparam int          LONG_STALL_CYCLES = 120;
	localparam int          TAIL_CYCLES       = 20;	// wait after the last expected result

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic        out_ready = 1'b0;
	stamp_pair_t drv       = '0;

	day_result_t got;

	stamp_pair_t pending_pairs[$];
	day_result_t due_results[$];

	int          total_pairs     = 0;
	int          accepted        = 0;
	int          results_seen    = 0;
	int          errors          = 0;
	logic        in_taken        = 1'b0;
	int unsigned send_idle       = 0;
	int unsigned recv_idle       = 0;
	bit          long_stall_done = 1'b0;

	gregorian_datetime_day_number u_top (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_valid             (in_valid),
		.in_ready             (in_ready),
		.first_year           (drv.first.year),
		.first_month          (drv.first.month),
		.first_day            (drv.first.day),
		.first_hour           (drv.first.hour),
		.first_minute         (drv.first.minute),
		.first_second         (drv.first.second),
		.other_year           (drv.other.year),
		.other_month          (drv.other.month),
		.other_day            (drv.other.day),
		.other_hour           (drv.other.hour),
		.other_minute         (drv.other.minute),
		.other_second         (drv.other.second),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.both_valid           (got.both_valid),
		.first_day_number     (got.first_day_number),
		.first_seconds_of_day (got.first_seconds_of_day),
		.weekday              (got.weekday),
		.gap_days             (got.gap_days),
		.gap_hours            (got.gap_hours),
		.gap_minutes          (got.gap_minutes),
		.gap_seconds          (got.gap_seconds)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Calendar arithmetic
	// ------------------------------------------------------------------

	function automatic bit is_leap(int unsigned y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	// month must already be 1..12
	function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
		case (m)
			2:             return is_leap(y) ? 29 : 28;
			4, 6, 9, 11:   return 30;
			default:       return 31;
		endcase
	endfunction

	function automatic bit stamp_ok(stamp_t s);
		if (s.year < 1582 || s.month < 1 || s.month > 12)
			return 1'b0;
		if (s.day < 1 || s.day > days_in_month(s.year, s.month))
			return 1'b0;
		return s.hour < 24 && s.minute < 60 && s.second < 60;
	endfunction

	// Meeus day number in whole integers; January and February belong to the
	// previous year as months 13 and 14
	function automatic int unsigned julian_day(int unsigned y, int unsigned m, int unsigned d);
		int unsigned cent;
		if (m <= 2) begin
			y = y - 1;
			m = m + 12;
		end
		cent = y / 100;
		return (1461 * (y + 4716)) / 4 + (153 * (m + 1)) / 5 + d + 2 + cent / 4 - cent - 1524;
	endfunction

	function automatic int unsigned day_seconds(stamp_t s);
		return s.hour * 3600 + s.minute * 60 + s.second;
	endfunction

	function automatic day_result_t compute_day_result(stamp_pair_t p);
		day_result_t     r;
		int unsigned     jd_first;
		int unsigned     rem;
		longint unsigned t_first;
		longint unsigned t_other;
		longint unsigned span;
		r = '0;
		if (!stamp_ok(p.first) || !stamp_ok(p.other))
			return r;
		jd_first = julian_day(p.first.year, p.first.month, p.first.day);
		t_first  = longint'(jd_first) * DAY_SECONDS + day_seconds(p.first);
		t_other  = longint'(julian_day(p.other.year, p.other.month, p.other.day)) * DAY_SECONDS
			+ day_seconds(p.other);
		span = (t_first >= t_other) ? t_first - t_other : t_other - t_first;
		rem  = 32'(span % DAY_SECONDS);
		r.both_valid           = 1'b1;
		r.first_day_number     = gdn_pkg::JDN_W'(jd_first);
		r.first_seconds_of_day = gdn_pkg::SOD_W'(day_seconds(p.first));
		r.weekday              = gdn_pkg::WD_W'((jd_first % 7) + 1);
		r.gap_days             = gdn_pkg::JDN_W'(span / DAY_SECONDS);
		r.gap_hours            = gdn_pkg::HOUR_W'(rem / 3600);
		r.gap_minutes          = gdn_pkg::MIN_W'((rem % 3600) / 60);
		r.gap_seconds          = gdn_pkg::SEC_W'(rem % 60);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic stamp_t mk(int unsigned y, int unsigned mo, int unsigned d,
			int unsigned h, int unsigned mi, int unsigned s);
		stamp_t t;
		t.year   = gdn_pkg::YEAR_W'(y);
		t.month  = gdn_pkg::MONTH_W'(mo);
		t.day    = gdn_pkg::DAY_W'(d);
		t.hour   = gdn_pkg::HOUR_W'(h);
		t.minute = gdn_pkg::MIN_W'(mi);
		t.second = gdn_pkg::SEC_W'(s);
		return t;
	endfunction

	function automatic void add_pair(stamp_t a, stamp_t b, bit drain);
		stamp_pair_t p;
		p.first          = a;
		p.other          = b;
		p.hold_for_drain = drain;
		pending_pairs.push_back(p);
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_idle();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic stamp_t random_good_stamp();
		stamp_t      s;
		int unsigned r;
		int unsigned len;
		r = $urandom_range(0, 99);
		if (r < 60)
			s.year = gdn_pkg::YEAR_W'($urandom_range(1582, 2600));
		else if (r < 80)
			s.year = gdn_pkg::YEAR_W'($urandom_range(1582, 9999));
		else if (r < 88)
			s.year = gdn_pkg::YEAR_W'($urandom_range(10000, 16383));
		else begin
			case ($urandom_range(0, 9))
				0: s.year = gdn_pkg::YEAR_W'(1582);
				1: s.year = gdn_pkg::YEAR_W'(1583);
				2: s.year = gdn_pkg::YEAR_W'(1600);
				3: s.year = gdn_pkg::YEAR_W'(1700);
				4: s.year = gdn_pkg::YEAR_W'(1900);
				5: s.year = gdn_pkg::YEAR_W'(2000);
				6: s.year = gdn_pkg::YEAR_W'(2100);
				7: s.year = gdn_pkg::YEAR_W'(2400);
				8: s.year = gdn_pkg::YEAR_W'(9999);
				default: s.year = gdn_pkg::YEAR_W'(16383);
			endcase
		end
		s.month = gdn_pkg::MONTH_W'($urandom_range(1, 12));
		len     = days_in_month(s.year, s.month);
		r       = $urandom_range(0, 99);
		s.day   = gdn_pkg::DAY_W'((r < 25) ? len : (r < 35) ? 1 : $urandom_range(1, len));
		if ($urandom_range(0, 4) == 0) begin
			// ends of the day
			s.hour   = gdn_pkg::HOUR_W'($urandom_range(0, 1) ? 23 : 0);
			s.minute = gdn_pkg::MIN_W'($urandom_range(0, 1) ? 59 : 0);
			s.second = gdn_pkg::SEC_W'($urandom_range(0, 1) ? 59 : 0);
		end else begin
			s.hour   = gdn_pkg::HOUR_W'($urandom_range(0, 23));
			s.minute = gdn_pkg::MIN_W'($urandom_range(0, 59));
			s.second = gdn_pkg::SEC_W'($urandom_range(0, 59));
		end
		return s;
	endfunction

	// a valid stamp close to a given one, so that small gaps in either
	// direction are common
	function automatic stamp_t nearby_stamp(stamp_t s);
		stamp_t t;
		t        = s;
		t.hour   = gdn_pkg::HOUR_W'($urandom_range(0, 23));
		t.minute = gdn_pkg::MIN_W'($urandom_range(0, 59));
		t.second = gdn_pkg::SEC_W'($urandom_range(0, 59));
		if ($urandom_range(0, 1))
			t.day = gdn_pkg::DAY_W'($urandom_range(1, days_in_month(t.year, t.month)));
		return t;
	endfunction

	// push exactly one field of a valid stamp out of range
	function automatic stamp_t break_stamp(stamp_t s);
		stamp_t      t;
		int unsigned len;
		t   = s;
		len = days_in_month(s.year, s.month);
		case ($urandom_range(0, 5))
			0: t.year   = gdn_pkg::YEAR_W'($urandom_range(0, 1581));
			1: t.month  = gdn_pkg::MONTH_W'($urandom_range(0, 3) == 0 ? 0
				: $urandom_range(13, 15));
			2: t.day    = gdn_pkg::DAY_W'((len == 31 || $urandom_range(0, 2) == 0) ? 0
				: $urandom_range(len + 1, 31));
			3: t.hour   = gdn_pkg::HOUR_W'($urandom_range(24, 31));
			4: t.minute = gdn_pkg::MIN_W'($urandom_range(60, 63));
			default: t.second = gdn_pkg::SEC_W'($urandom_range(60, 63));
		endcase
		return t;
	endfunction

	function automatic stamp_t noise_stamp();
		stamp_t s;
		s.year   = gdn_pkg::YEAR_W'($urandom_range(0, 16383));
		s.month  = gdn_pkg::MONTH_W'($urandom_range(0, 15));
		s.day    = gdn_pkg::DAY_W'($urandom_range(0, 31));
		s.hour   = gdn_pkg::HOUR_W'($urandom_range(0, 31));
		s.minute = gdn_pkg::MIN_W'($urandom_range(0, 63));
		s.second = gdn_pkg::SEC_W'($urandom_range(0, 63));
		return s;
	endfunction

	function automatic void note_field(string name, longint unsigned want, longint unsigned seen);
		if (want !== seen) begin
			errors++;
			if (errors <= 10)
				$display("result %0d: %s expected %0d, got %0d", results_seen, name, want, seen);
		end
	endfunction

	// ------------------------------------------------------------------
	// Sender: offers the queued pairs at the falling edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (send_idle != 0) begin
				send_idle--;
				in_valid <= 1'b0;
			end else if (pending_pairs.size() != 0
					&& !(pending_pairs[0].hold_for_drain && due_results.size() != 0)) begin
				drv = pending_pairs.pop_front();
				in_valid <= 1'b1;
				// every third stretch of 150 transactions runs back to back
				send_idle = ((accepted / 150) % 3 == 0) ? 0 : pick_idle();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random back-pressure plus one long hold-off that fills the
	// pipeline and pushes the stall back to the input side
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (!long_stall_done && results_seen >= LONG_STALL_AT) begin
			long_stall_done = 1'b1;
			recv_idle       = LONG_STALL_CYCLES;
			out_ready <= 1'b0;
		end else if (recv_idle != 0) begin
			recv_idle--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ((results_seen / 170) % 3 != 1 && $urandom_range(0, 3) == 0)
				recv_idle = pick_idle();
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each result transaction against the oldest prediction,
	// then records a newly accepted input transaction
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		day_result_t want;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("result %0d arrived with nothing outstanding", results_seen);
				end else begin
					want = due_results.pop_front();
					note_field("both_valid", want.both_valid, got.both_valid);
					note_field("first_day_number", want.first_day_number, got.first_day_number);
					note_field("first_seconds_of_day", want.first_seconds_of_day,
						got.first_seconds_of_day);
					note_field("weekday", want.weekday, got.weekday);
					note_field("gap_days", want.gap_days, got.gap_days);
					note_field("gap_hours", want.gap_hours, got.gap_hours);
					note_field("gap_minutes", want.gap_minutes, got.gap_minutes);
					note_field("gap_seconds", want.gap_seconds, got.gap_seconds);
				end
				results_seen++;
			end
			if (in_valid && in_ready) begin
				due_results.push_back(compute_day_result(drv));
				accepted++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		stamp_t a;
		stamp_t b;
		int     r;

		// directed: range ends, leap rules, each kind of invalid field
		add_pair(mk(1582, 1, 1, 0, 0, 0), mk(1582, 1, 1, 0, 0, 0), 1'b0);
		add_pair(mk(9999, 12, 31, 23, 59, 59), mk(1582, 1, 1, 0, 0, 0), 1'b0);
		add_pair(mk(1582, 1, 1, 0, 0, 0), mk(16383, 12, 31, 23, 59, 59), 1'b0);
		add_pair(mk(16383, 12, 31, 23, 59, 59), mk(10000, 1, 1, 12, 30, 30), 1'b0);
		add_pair(mk(2000, 2, 29, 12, 0, 0), mk(2000, 3, 1, 11, 59, 59), 1'b0);
		add_pair(mk(2024, 2, 29, 6, 7, 8), mk(2023, 12, 31, 23, 59, 59), 1'b0);
		add_pair(mk(2100, 2, 28, 0, 0, 1), mk(2000, 1, 1, 0, 0, 0), 1'b0);
		add_pair(mk(1900, 2, 29, 0, 0, 0), mk(2000, 1, 1, 0, 0, 0), 1'b0);
		add_pair(mk(2023, 2, 29, 0, 0, 0), mk(2000, 1, 1, 0, 0, 0), 1'b0);
		add_pair(mk(2000, 1, 1, 0, 0, 0), mk(2000, 1, 2, 0, 0, 1), 1'b0);
		add_pair(mk(2000, 3, 1, 0, 0, 0), mk(2000, 2, 28, 23, 59, 59), 1'b0);
		add_pair(mk(1581, 12, 31, 23, 59, 59), mk(1582, 1, 1, 0, 0, 0), 1'b0);
		add_pair(mk(2000, 0, 1, 0, 0, 0), mk(2000, 1, 1, 0, 0, 0), 1'b0);
		add_pair(mk(2000, 13, 1, 0, 0, 0), mk(2000, 1, 1, 0, 0, 0), 1'b0);
		add_pair(mk(2000, 1, 1, 0, 0, 0), mk(2000, 15, 1, 0, 0, 0), 1'b0);
		add_pair(mk(2000, 1, 0, 0, 0, 0), mk(2000, 1, 1, 0, 0, 0), 1'b0);
		add_pair(mk(2000, 4, 31, 0, 0, 0), mk(2000, 1, 1, 0, 0, 0), 1'b0);
		add_pair(mk(2000, 1, 1, 24, 0, 0), mk(2000, 1, 1, 0, 0, 0), 1'b0);
		add_pair(mk(2000, 1, 1, 0, 60, 0), mk(2000, 1, 1, 0, 0, 0), 1'b0);
		add_pair(mk(2000, 1, 1, 0, 0, 0), mk(2000, 1, 1, 0, 0, 63), 1'b0);
		add_pair(mk(0, 0, 0, 0, 0, 0), mk(0, 0, 0, 0, 0, 0), 1'b0);
		add_pair(mk(16383, 15, 31, 31, 63, 63), mk(16383, 15, 31, 31, 63, 63), 1'b0);

		// random: mostly valid pairs, some with one field broken, some noise.
		// The first random pair and one midway wait for an empty pipeline.
		for (int i = 0; i < RANDOM_PAIRS; i++) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				a = random_good_stamp();
				b = ($urandom_range(0, 9) < 4) ? nearby_stamp(a) : random_good_stamp();
			end else if (r < 90) begin
				a = random_good_stamp();
				b = random_good_stamp();
				case ($urandom_range(0, 4))
					0, 1: a = break_stamp(a);
					2, 3: b = break_stamp(b);
					default: begin
						a = break_stamp(a);
						b = break_stamp(b);
					end
				endcase
			end else begin
				a = noise_stamp();
				b = ($urandom_range(0, 1)) ? noise_stamp() : random_good_stamp();
			end
			add_pair(a, b, i == 0 || i == 700);
		end
		total_pairs = pending_pairs.size();

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		while (accepted < total_pairs)
			@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		// catch any stray result transaction after the last expected one
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0 && due_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
